>>> rtl/spjs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spjs_pkg
// Shared types, constants and helpers of the step pulse job sequencer.
// ----------------------------------------------------------------------------
package spjs_pkg;

	typedef enum logic [2:0] {
		CMD_RUN_STEPS = 3'd0,
		CMD_RUN_MM    = 3'd1,
		CMD_PAUSE     = 3'd2,
		CMD_RESUME    = 3'd3,
		CMD_ABORT     = 3'd4,
		CMD_SLOT      = 3'd5
	} cmd_t;

	// Register indexes of the configuration port (byte address is 4 * index).
	localparam logic [2:0] REG_RAMP_ENABLE    = 3'd0;
	localparam logic [2:0] REG_RAMP_LENGTH    = 3'd1;
	localparam logic [2:0] REG_CRUISE_DIVIDER = 3'd2;
	localparam logic [2:0] REG_SLOW_DIVIDER   = 3'd3;
	localparam logic [2:0] REG_DIVIDER_STEP   = 3'd4;

	localparam logic        RST_RAMP_ENABLE    = 1'b1;
	localparam logic [15:0] RST_RAMP_LENGTH    = 16'd100;
	localparam logic [15:0] RST_CRUISE_DIVIDER = 16'd10;
	localparam logic [15:0] RST_SLOW_DIVIDER   = 16'd100;
	localparam logic [15:0] RST_DIVIDER_STEP   = 16'd1;

	localparam int STEPS_PER_BYTE = 5;
	localparam int PREFILL_BYTES  = 5;
	localparam int MAX_RESULTS    = 5;

	localparam logic [7:0]  FULL_BYTE    = 8'h55;
	localparam logic [29:0] DIRECT_LIMIT = 30'd4;
	localparam logic [2:0]  BURST_BYTES  =
		3'(PREFILL_BYTES < MAX_RESULTS ? PREFILL_BYTES : MAX_RESULTS);
	localparam logic [2:0]  MAX_RESULT_CNT = 3'(MAX_RESULTS);

	// Reciprocal of five: (x * RECIP_5) >> 34 is x / 5 for every 32-bit x.
	localparam logic [31:0] RECIP_5 = 32'hCCCC_CCCD;

	typedef struct packed {
		logic        ramp_enable;
		logic [15:0] ramp_length;
		logic [15:0] cruise_divider;
		logic [15:0] slow_divider;
		logic [15:0] divider_step;
	} cfg_t;

	typedef struct packed {
		logic       capture;
		logic       mul;
		logic       div;
		logic       load;
		logic       ramp_up;
		logic       ramp_dn;
		logic       exec;
		logic       out_load;
		logic       out_last;
		logic [2:0] out_idx;
	} dp_cmd_t;

	typedef struct packed {
		logic       busy;
		logic       slot_ramp;
		logic [2:0] n_bytes;
	} dp_stat_t;

	function automatic logic [7:0] tail_byte(input logic [2:0] pulses);
		logic [7:0] b;
		case (pulses)
			3'd1: b = 8'h00;
			3'd2: b = 8'h01;
			3'd3: b = 8'h05;
			3'd4: b = 8'h15;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

>>> rtl/spjs_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spjs_cfg
// Configuration registers behind a 32-bit APB-style port.
// ----------------------------------------------------------------------------
module spjs_cfg import spjs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output cfg_t             cfg
);

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[4:2];
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ramp_enable    <= RST_RAMP_ENABLE;
			cfg_q.ramp_length    <= RST_RAMP_LENGTH;
			cfg_q.cruise_divider <= RST_CRUISE_DIVIDER;
			cfg_q.slow_divider   <= RST_SLOW_DIVIDER;
			cfg_q.divider_step   <= RST_DIVIDER_STEP;
		end else if (wr_en) begin
			case (reg_idx)
				REG_RAMP_ENABLE:    cfg_q.ramp_enable    <= pwdata[0];
				REG_RAMP_LENGTH:    cfg_q.ramp_length    <= pwdata[15:0];
				REG_CRUISE_DIVIDER: cfg_q.cruise_divider <= pwdata[15:0];
				REG_SLOW_DIVIDER:   cfg_q.slow_divider   <= pwdata[15:0];
				REG_DIVIDER_STEP:   cfg_q.divider_step   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_RAMP_ENABLE:    prdata = {31'd0, cfg_q.ramp_enable};
			REG_RAMP_LENGTH:    prdata = {16'd0, cfg_q.ramp_length};
			REG_CRUISE_DIVIDER: prdata = {16'd0, cfg_q.cruise_divider};
			REG_SLOW_DIVIDER:   prdata = {16'd0, cfg_q.slow_divider};
			REG_DIVIDER_STEP:   prdata = {16'd0, cfg_q.divider_step};
			default:            prdata = 32'd0;
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/spjs_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spjs_dp
// Datapath: job state, step count split, divider ramp and result register.
// ----------------------------------------------------------------------------
module spjs_dp import spjs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire dp_cmd_t     cmd,
	output dp_stat_t         stat,
	input  wire logic [2:0]  command,
	input  wire logic [31:0] step_count,
	input  wire logic [15:0] job_length,
	input  wire logic [15:0] steps_per_mm,
	input  wire logic        direction_in,
	output logic [7:0]       pulse_byte,
	output logic             byte_valid,
	output logic [15:0]      clock_divider,
	output logic             divider_changed,
	output logic             direction_out,
	output logic             running,
	output logic             slots_enabled,
	output logic             last
);

	// Captured item.
	logic [2:0]  cmd_q;
	logic [31:0] steps_q;
	logic [15:0] len_q;
	logic [15:0] spm_q;
	logic        dir_in_q;
	logic [63:0] prod_q;

	// Job state.
	logic [29:0] bytes_left_q;
	logic [2:0]  tail_q;
	logic [29:0] job_bytes_q;
	logic [15:0] div_now_q;
	logic [15:0] div_applied_q;
	logic        busy_q;
	logic        pp_q;
	logic        se_q;
	logic        dir_q;
	logic        changed_q;

	// Emission plan of the current item.
	logic [2:0]  full_cnt_q;
	logic        tflag_q;
	logic [7:0]  tval_q;

	// Result register.
	logic [7:0]  pulse_byte_q;
	logic        byte_valid_q;
	logic [15:0] clock_divider_q;
	logic        divider_changed_q;
	logic        direction_out_q;
	logic        running_q;
	logic        slots_enabled_q;
	logic        last_q;

	logic [29:0] quot;
	logic [2:0]  q5_lo;
	logic [2:0]  rem;

	logic [29:0] bl_n;
	logic [2:0]  tp_n;
	logic        busy_n;
	logic        pp_n;
	logic        se_n;
	logic [2:0]  full_n;
	logic        tflag_n;
	logic        do_burst;
	logic        tail_ok;

	logic        up_hit;
	logic [15:0] d_up;
	logic [16:0] d_sum;
	logic [15:0] d_dn;
	logic [2:0]  n_bytes;

	assign quot  = prod_q[63:34];
	assign q5_lo = quot[2:0] + {quot[0], 2'b00};
	assign rem   = steps_q[2:0] - q5_lo;

	assign tail_ok = (tail_q >= 3'd1) && (tail_q <= 3'd4);
	assign n_bytes = full_cnt_q + {2'b00, tflag_q};

	assign stat.busy      = busy_q;
	assign stat.slot_ramp = se_q & cfg.ramp_enable;
	assign stat.n_bytes   = n_bytes;

	// Next job state of the executed command.
	always_comb begin
		bl_n     = bytes_left_q;
		tp_n     = tail_q;
		busy_n   = busy_q;
		pp_n     = pp_q;
		se_n     = se_q;
		full_n   = 3'd0;
		tflag_n  = 1'b0;
		do_burst = 1'b0;
		case (cmd_q)
			CMD_RUN_STEPS, CMD_RUN_MM: begin
				do_burst = !busy_q;
			end
			CMD_PAUSE: begin
				if (busy_q) pp_n = 1'b1;
			end
			CMD_RESUME: begin
				if (busy_q) begin
					pp_n     = 1'b0;
					do_burst = !se_q;
				end
			end
			CMD_ABORT: begin
				bl_n   = '0;
				tp_n   = '0;
				busy_n = 1'b0;
				pp_n   = 1'b0;
				se_n   = 1'b0;
			end
			CMD_SLOT: begin
				if (se_q) begin
					if (pp_q) begin
						pp_n = 1'b0;
						se_n = 1'b0;
					end else if (bytes_left_q != '0) begin
						full_n = 3'd1;
						bl_n   = bytes_left_q - 30'd1;
					end else if (busy_q) begin
						tflag_n = tail_ok;
						tp_n    = '0;
						busy_n  = 1'b0;
					end else begin
						se_n = 1'b0;
					end
				end
			end
			default: ;
		endcase
		if (do_burst) begin
			se_n = 1'b1;
			if (bytes_left_q <= DIRECT_LIMIT) begin
				// Short remainder: everything goes out now and the job ends.
				full_n  = bytes_left_q[2:0];
				tflag_n = tail_ok;
				tp_n    = '0;
				bl_n    = '0;
				busy_n  = 1'b0;
			end else begin
				full_n = BURST_BYTES;
				bl_n   = bytes_left_q - 30'(BURST_BYTES);
				busy_n = 1'b1;
			end
		end
	end

	// Divider ramp, split into the fall toward cruise and then the rise, each in its own state.
	always_comb begin
		up_hit = (job_bytes_q >= {14'd0, cfg.ramp_length}) &&
			(bytes_left_q > (job_bytes_q - {14'd0, cfg.ramp_length}));
		d_up = div_now_q;
		if (up_hit) begin
			if (div_now_q > cfg.cruise_divider) begin
				d_up = (div_now_q >= cfg.divider_step) ? div_now_q - cfg.divider_step : 16'd0;
			end else begin
				d_up = cfg.cruise_divider;
			end
		end
		d_sum = {1'b0, div_now_q} + {1'b0, cfg.divider_step};
		d_dn  = div_now_q;
		if ((bytes_left_q <= {14'd0, cfg.ramp_length}) && (div_now_q < cfg.slow_divider)) begin
			d_dn = d_sum[16] ? 16'hFFFF : d_sum[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q    <= command;
			steps_q  <= step_count;
			len_q    <= job_length;
			spm_q    <= steps_per_mm;
			dir_in_q <= direction_in;
		end
		if (cmd.mul) steps_q <= 32'(len_q) * 32'(spm_q);
		if (cmd.div) prod_q <= {32'd0, steps_q} * {32'd0, RECIP_5};
		if (cmd.exec) begin
			tval_q <= tail_byte(tail_q);
		end
		if (cmd.out_load) begin
			if (n_bytes == 3'd0) begin
				pulse_byte_q <= 8'h00;
			end else if (cmd.out_idx < full_cnt_q) begin
				pulse_byte_q <= FULL_BYTE;
			end else begin
				pulse_byte_q <= tval_q;
			end
			byte_valid_q      <= (n_bytes != 3'd0);
			clock_divider_q   <= div_now_q;
			divider_changed_q <= changed_q;
			direction_out_q   <= dir_q;
			running_q         <= busy_q;
			slots_enabled_q   <= se_q;
			last_q            <= cmd.out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q  <= '0;
			tail_q        <= '0;
			job_bytes_q   <= '0;
			div_now_q     <= RST_RAMP_ENABLE ? RST_SLOW_DIVIDER : RST_CRUISE_DIVIDER;
			div_applied_q <= '0;
			busy_q        <= 1'b0;
			pp_q          <= 1'b0;
			se_q          <= 1'b0;
			dir_q         <= 1'b0;
			changed_q     <= 1'b0;
			full_cnt_q    <= '0;
			tflag_q       <= 1'b0;
		end else begin
			if (cmd.capture) changed_q <= 1'b0;
			if (cmd.load) begin
				bytes_left_q <= quot;
				tail_q       <= rem;
				job_bytes_q  <= quot;
				if (cmd_q == CMD_RUN_MM) begin
					dir_q     <= dir_in_q;
					div_now_q <= cfg.ramp_enable ? cfg.slow_divider : cfg.cruise_divider;
					changed_q <= 1'b1;
				end
			end
			if (cmd.ramp_up) div_now_q <= d_up;
			if (cmd.ramp_dn) begin
				div_now_q <= d_dn;
				if (d_dn != div_applied_q) begin
					div_applied_q <= d_dn;
					changed_q     <= 1'b1;
				end
			end
			if (cmd.exec) begin
				bytes_left_q <= bl_n;
				tail_q       <= tp_n;
				busy_q       <= busy_n;
				pp_q         <= pp_n;
				se_q         <= se_n;
				full_cnt_q   <= full_n;
				tflag_q      <= tflag_n;
			end
		end
	end

	assign pulse_byte      = pulse_byte_q;
	assign byte_valid      = byte_valid_q;
	assign clock_divider   = clock_divider_q;
	assign divider_changed = divider_changed_q;
	assign direction_out   = direction_out_q;
	assign running         = running_q;
	assign slots_enabled   = slots_enabled_q;
	assign last            = last_q;

	a_plan_fits: assert property (@(posedge clk) disable iff (!arst_n)
		n_bytes <= MAX_RESULT_CNT)
		else $error("emission plan exceeds the result limit");

endmodule
`default_nettype wire

>>> rtl/spjs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spjs_ctrl
// Controller: sequences one command through the datapath and its results out.
// ----------------------------------------------------------------------------
module spjs_ctrl import spjs_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [2:0] command,
	output logic            out_valid,
	input  wire logic       out_ready,
	output dp_cmd_t         cmd,
	input  wire dp_stat_t   stat
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_LOAD,
		S_RAMP_UP,
		S_RAMP_DN,
		S_EXEC,
		S_EMIT
	} state_t;

	state_t     state_q;
	logic [2:0] idx_q;
	logic       out_valid_q;
	logic       in_xfer;
	logic       is_start;
	logic       emit_go;
	logic [2:0] last_idx;
	logic       is_last;

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid & in_ready;
	assign is_start = (command == CMD_RUN_STEPS) || (command == CMD_RUN_MM);
	assign emit_go  = (state_q == S_EMIT) && (!out_valid_q || out_ready);
	assign last_idx = (stat.n_bytes == 3'd0) ? 3'd0 : stat.n_bytes - 3'd1;
	assign is_last  = (idx_q == last_idx);

	always_comb begin
		cmd          = '0;
		cmd.capture  = in_xfer;
		cmd.mul      = (state_q == S_MUL);
		cmd.div      = (state_q == S_DIV);
		cmd.load     = (state_q == S_LOAD);
		cmd.ramp_up  = (state_q == S_RAMP_UP);
		cmd.ramp_dn  = (state_q == S_RAMP_DN);
		cmd.exec     = (state_q == S_EXEC);
		cmd.out_load = emit_go;
		cmd.out_last = is_last;
		cmd.out_idx  = idx_q;
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_go) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (in_xfer) begin
						if (is_start && !stat.busy) begin
							state_q <= (command == CMD_RUN_MM) ? S_MUL : S_DIV;
						end else if ((command == CMD_SLOT) && stat.slot_ramp) begin
							state_q <= S_RAMP_UP;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_MUL:     state_q <= S_DIV;
				S_DIV:     state_q <= S_LOAD;
				S_LOAD:    state_q <= S_EXEC;
				S_RAMP_UP: state_q <= S_RAMP_DN;
				S_RAMP_DN: state_q <= S_EXEC;
				S_EXEC:    state_q <= S_EMIT;
				S_EMIT: begin
					if (emit_go) begin
						idx_q <= idx_q + 3'd1;
						if (is_last) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("second item accepted while one is in work");

	a_exec_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |=> (state_q == S_EMIT) && !in_ready)
		else $error("executed command did not move to result output");

	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && is_last) |=> out_valid_q && in_ready)
		else $error("final result not followed by a free input side");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (idx_q <= last_idx))
		else $error("result index ran past the planned count");

endmodule
`default_nettype wire

>>> rtl/step_pulse_job_sequencer_with_ramp_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// step_pulse_job_sequencer_with_ramp_top
// Stepper job sequencer that turns commands into pulse bytes with a ramped
// pulse clock divider.
// ----------------------------------------------------------------------------
// Usage: commands enter on the in_valid/in_ready channel, one per transfer.
// Each command yields one to five results on out_valid/out_ready: one per
// pulse byte emitted, or a single result with byte_valid low when no byte is
// sent; last marks the final result of a command. Status fields show the
// state after the command.
// A run_steps that starts a job passes the divide (32x32 reciprocal
// multiply), load and execute states; a run_mm that starts one first passes
// the multiply state (16x16); a slot event with slots enabled and ramping
// on passes the divider ramp fall and rise states before execute; all other
// commands go straight to execute. Results then leave one per cycle while
// the receiver accepts them; the next command is taken in the cycle after
// its predecessor's final result is registered. The result register holds
// its data while the receiver stalls and the block waits before loading
// the next result. Reset clears the job state, loads the register defaults
// and sets the divider to the slow value. Registers are to be written over
// the APB port only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module step_pulse_job_sequencer_with_ramp_top import spjs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  command,
	input  wire logic [31:0] step_count,
	input  wire logic [15:0] job_length,
	input  wire logic [15:0] steps_per_mm,
	input  wire logic        direction_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       pulse_byte,
	output logic             byte_valid,
	output logic [15:0]      clock_divider,
	output logic             divider_changed,
	output logic             direction_out,
	output logic             running,
	output logic             slots_enabled,
	output logic             last
);

	cfg_t     cfg;
	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	spjs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	spjs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (dp_cmd),
		.stat      (dp_stat)
	);

	spjs_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.cmd             (dp_cmd),
		.stat            (dp_stat),
		.command         (command),
		.step_count      (step_count),
		.job_length      (job_length),
		.steps_per_mm    (steps_per_mm),
		.direction_in    (direction_in),
		.pulse_byte      (pulse_byte),
		.byte_valid      (byte_valid),
		.clock_divider   (clock_divider),
		.divider_changed (divider_changed),
		.direction_out   (direction_out),
		.running         (running),
		.slots_enabled   (slots_enabled),
		.last            (last)
	);

endmodule
`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the step pulse job sequencer with divider ramp.
// A directed table covers idle commands, every tail byte, long jobs, pause,
// resume and abort, and the short resume that ends a job. Random job
// sequences then run under several ramp profiles. Every command is run
// through an in-bench predictor, and each result transfer is checked field by
// field against the oldest expected result.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import spjs_pkg::*;

	localparam logic [2:0] CMD_UNUSED    = 3'd6;

	localparam int LONG_HOLD     = 200;
	localparam int DRAIN_CYCLES  = 20;
	localparam int QUIET_LIMIT   = 2000;
	localparam int PHASE_ITEMS   = 45;
	localparam int MAX_SHOWN     = 10;

	localparam logic [7:0] TAIL_CODE [4] = '{8'h00, 8'h01, 8'h05, 8'h15};

	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] steps;
		logic [15:0] len;
		logic [15:0] spm;
		logic        dir;
		logic        typed;
		logic [7:0]  t_pulse;
		logic        t_sent;
		logic        t_busy;
		logic        t_slots;
	} stim_t;

	typedef struct packed {
		logic [7:0]  pulse;
		logic        sent;
		logic [15:0] divider;
		logic        changed;
		logic        dir;
		logic        busy;
		logic        slots;
		logic        closing;
	} pulse_result_t;

	// Typed columns give the final result of the command where it is obvious.
	localparam stim_t DIRECTED [27] = '{
		'{CMD_SLOT,      32'd0,          16'd0,     16'd0,     1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0},
		'{CMD_PAUSE,     32'd0,          16'd0,     16'd0,     1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0},
		'{CMD_RESUME,    32'd0,          16'd0,     16'd0,     1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0},
		'{CMD_UNUSED,    32'hFFFF_FFFF,  16'hFFFF,  16'hFFFF,  1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0},
		'{CMD_RUN_STEPS, 32'd0,          16'd0,     16'd0,     1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1},
		'{CMD_SLOT,      32'd0,          16'd0,     16'd0,     1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0},
		'{CMD_RUN_STEPS, 32'd1,          16'd0,     16'd0,     1'b0, 1'b1, 8'h00, 1'b1, 1'b0, 1'b1},
		'{CMD_RUN_STEPS, 32'd2,          16'd0,     16'd0,     1'b0, 1'b1, 8'h01, 1'b1, 1'b0, 1'b1},
		'{CMD_RUN_STEPS, 32'd3,          16'd0,     16'd0,     1'b0, 1'b1, 8'h05, 1'b1, 1'b0, 1'b1},
		'{CMD_RUN_STEPS, 32'd4,          16'd0,     16'd0,     1'b0, 1'b1, 8'h15, 1'b1, 1'b0, 1'b1},
		'{CMD_RUN_STEPS, 32'd24,         16'd0,     16'd0,     1'b0, 1'b1, 8'h15, 1'b1, 1'b0, 1'b1},
		'{CMD_SLOT,      32'd0,          16'd0,     16'd0,     1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0},
		'{CMD_RUN_STEPS, 32'hFFFF_FFFF,  16'd0,     16'd0,     1'b0, 1'b1, 8'h55, 1'b1, 1'b1, 1'b1},
		'{CMD_RUN_STEPS, 32'd7,          16'd0,     16'd0,     1'b0, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1},
		'{CMD_SLOT,      32'd0,          16'd0,     16'd0,     1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
		'{CMD_PAUSE,     32'd0,          16'd0,     16'd0,     1'b0, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1},
		'{CMD_SLOT,      32'd0,          16'd0,     16'd0,     1'b0, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0},
		'{CMD_RESUME,    32'd0,          16'd0,     16'd0,     1'b0, 1'b1, 8'h55, 1'b1, 1'b1, 1'b1},
		'{CMD_RESUME,    32'd0,          16'd0,     16'd0,     1'b0, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1},
		'{CMD_ABORT,     32'd0,          16'd0,     16'd0,     1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0},
		'{CMD_RUN_MM,    32'd0,          16'hFFFF,  16'hFFFF,  1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
		'{CMD_ABORT,     32'd0,          16'd0,     16'd0,     1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0},
		'{CMD_RUN_MM,    32'd0,          16'd0,     16'd0,     1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1},
		'{CMD_RUN_MM,    32'd0,          16'd3,     16'd9,     1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
		'{CMD_PAUSE,     32'd0,          16'd0,     16'd0,     1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
		'{CMD_SLOT,      32'd0,          16'd0,     16'd0,     1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
		'{CMD_RESUME,    32'd0,          16'd0,     16'd0,     1'b0, 1'b1, 8'h01, 1'b1, 1'b0, 1'b1}
	};

	// Field order: ramp_enable, ramp_length, cruise_divider, slow_divider, divider_step.
	localparam cfg_t RAMP_PROFILES [5] = '{
		'{1'b0, 16'd0,     16'd65535, 16'd1,     16'd65535},
		'{1'b1, 16'd0,     16'd1,     16'd65535, 16'd65535},
		'{1'b1, 16'd3,     16'd10,    16'd50,    16'd60},
		'{1'b1, 16'd65535, 16'd1,     16'd65535, 16'd0},
		'{1'b1, 16'd4,     16'd20,    16'd60,    16'd7}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  command = '0;
	logic [31:0] step_count = '0;
	logic [15:0] job_length = '0;
	logic [15:0] steps_per_mm = '0;
	logic        direction_in = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  pulse_byte;
	logic        byte_valid;
	logic [15:0] clock_divider;
	logic        divider_changed;
	logic        direction_out;
	logic        running;
	logic        slots_enabled;
	logic        last;

	step_pulse_job_sequencer_with_ramp_top uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .command(command),
		.step_count(step_count), .job_length(job_length),
		.steps_per_mm(steps_per_mm), .direction_in(direction_in),
		.out_valid(out_valid), .out_ready(out_ready), .pulse_byte(pulse_byte),
		.byte_valid(byte_valid), .clock_divider(clock_divider),
		.divider_changed(divider_changed), .direction_out(direction_out),
		.running(running), .slots_enabled(slots_enabled), .last(last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predicted sequencer state and register copy.
	cfg_t        cfg_now = '{RST_RAMP_ENABLE, RST_RAMP_LENGTH, RST_CRUISE_DIVIDER,
		RST_SLOW_DIVIDER, RST_DIVIDER_STEP};
	logic [29:0] left_bytes = '0;
	logic [2:0]  tail_steps = '0;
	logic [29:0] job_len = '0;
	logic [15:0] div_cur = RST_SLOW_DIVIDER;
	logic [15:0] div_last = '0;
	logic        job_busy = 1'b0;
	logic        pause_req = 1'b0;
	logic        slots_on = 1'b0;
	logic        dir_pin = 1'b0;
	logic [7:0]  emitted[$];

	pulse_result_t expected_results[$];
	stim_t         cur_stim = '0;

	int  failures = 0;
	int  results_seen = 0;
	int  items_sent = 0;
	int  items_acted = 0;
	int  quiet_cycles = 0;
	bit  calm = 1'b0;
	bit  held_off = 1'b0;

	function automatic void load_job(input logic [31:0] steps);
		left_bytes = 30'(steps / 32'(STEPS_PER_BYTE));
		tail_steps = 3'(steps % 32'(STEPS_PER_BYTE));
		job_len = left_bytes;
	endfunction

	function automatic void push_tail();
		if (tail_steps >= 3'd1 && tail_steps <= 3'd4)
			emitted.push_back(TAIL_CODE[tail_steps - 3'd1]);
		tail_steps = '0;
	endfunction

	// A short job goes out whole; a long one gets the prefill and stays busy.
	function automatic void start_burst();
		slots_on = 1'b1;
		if (left_bytes <= DIRECT_LIMIT) begin
			while (left_bytes != '0) begin
				emitted.push_back(FULL_BYTE);
				left_bytes--;
			end
			push_tail();
			job_busy = 1'b0;
		end else begin
			job_busy = 1'b1;
			for (int i = 0; i < int'(BURST_BYTES) && left_bytes != '0; i++) begin
				emitted.push_back(FULL_BYTE);
				left_bytes--;
			end
		end
	endfunction

	function automatic bit ramp_divider();
		logic [31:0] d;
		logic [31:0] jb;
		logic [31:0] bl;
		logic [31:0] rl;
		d = 32'(div_cur);
		jb = 32'(job_len);
		bl = 32'(left_bytes);
		rl = 32'(cfg_now.ramp_length);
		if (jb >= rl && bl > jb - rl) begin
			if (d > 32'(cfg_now.cruise_divider))
				d = (d >= 32'(cfg_now.divider_step)) ? d - 32'(cfg_now.divider_step) : '0;
			else
				d = 32'(cfg_now.cruise_divider);
		end
		if (bl <= rl && d < 32'(cfg_now.slow_divider)) begin
			d = d + 32'(cfg_now.divider_step);
			if (d > 32'hFFFF)
				d = 32'hFFFF;
		end
		div_cur = d[15:0];
		if (div_cur != div_last) begin
			div_last = div_cur;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic predict_command(input stim_t it);
		bit            chg;
		bit            acted;
		int            n;
		pulse_result_t r;
		chg = 1'b0;
		acted = 1'b0;
		emitted.delete();
		case (it.cmd)
			CMD_RUN_STEPS: if (!job_busy) begin
				acted = 1'b1;
				load_job(it.steps);
				start_burst();
			end
			CMD_RUN_MM: if (!job_busy) begin
				acted = 1'b1;
				dir_pin = it.dir;
				load_job(32'(it.len) * 32'(it.spm));
				div_cur = cfg_now.ramp_enable ? cfg_now.slow_divider : cfg_now.cruise_divider;
				chg = 1'b1;
				start_burst();
			end
			CMD_PAUSE: if (job_busy) begin
				acted = 1'b1;
				pause_req = 1'b1;
			end
			CMD_RESUME: if (job_busy) begin
				acted = 1'b1;
				pause_req = 1'b0;
				if (!slots_on)
					start_burst();
			end
			CMD_ABORT: begin
				acted = 1'b1;
				left_bytes = '0;
				tail_steps = '0;
				job_busy = 1'b0;
				pause_req = 1'b0;
				slots_on = 1'b0;
			end
			CMD_SLOT: if (slots_on) begin
				acted = 1'b1;
				if (cfg_now.ramp_enable)
					chg = ramp_divider();
				if (pause_req) begin
					pause_req = 1'b0;
					slots_on = 1'b0;
				end else if (left_bytes != '0) begin
					emitted.push_back(FULL_BYTE);
					left_bytes--;
				end else if (job_busy) begin
					push_tail();
					job_busy = 1'b0;
				end else begin
					slots_on = 1'b0;
				end
			end
			default: ;
		endcase
		if (acted)
			items_acted++;
		n = (emitted.size() > 0) ? emitted.size() : 1;
		for (int k = 0; k < n; k++) begin
			r.pulse = (emitted.size() > 0) ? emitted[k] : 8'h00;
			r.sent = (emitted.size() > 0);
			r.divider = div_cur;
			r.changed = chg;
			r.dir = dir_pin;
			r.busy = job_busy;
			r.slots = slots_on;
			r.closing = (k == n - 1);
			if (k == n - 1 && it.typed) begin
				r.pulse = it.t_pulse;
				r.sent = it.t_sent;
				r.busy = it.t_busy;
				r.slots = it.t_slots;
			end
			expected_results.push_back(r);
		end
	endtask

	function automatic string show(input pulse_result_t r);
		return $sformatf("byte %h sent %b div %0d chg %b dir %b run %b slots %b last %b",
			r.pulse, r.sent, r.divider, r.changed, r.dir, r.busy, r.slots, r.closing);
	endfunction

	// Result check first, so a stray result never meets the expectations of a
	// command taken at the same edge.
	always @(posedge clk) begin : monitor
		pulse_result_t got;
		pulse_result_t want;
		bit            bad;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = '{pulse_byte, byte_valid, clock_divider, divider_changed,
					direction_out, running, slots_enabled, last};
				results_seen++;
				if (expected_results.size() == 0) begin
					failures++;
					if (failures <= MAX_SHOWN)
						$display("Unexpected result: %s", show(got));
				end else begin
					want = expected_results.pop_front();
					bad = (got.pulse !== want.pulse) || (got.sent !== want.sent) ||
						(got.divider !== want.divider) || (got.changed !== want.changed) ||
						(got.dir !== want.dir) || (got.busy !== want.busy) ||
						(got.slots !== want.slots) || (got.closing !== want.closing);
					if (bad) begin
						failures++;
						if (failures <= MAX_SHOWN) begin
							$display("Mismatch at result %0d", results_seen);
							$display("  expected %s", show(want));
							$display("  actual   %s", show(got));
						end
					end
				end
			end
			if (in_valid && in_ready)
				predict_command(cur_stim);
			if ((out_valid && out_ready) || (in_valid && in_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timeout: no transfer for %0d cycles, %0d results outstanding",
					quiet_cycles, expected_results.size());
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold-off so that the
	// block backs up into its input channel.
	initial begin : receiver
		int stall;
		forever begin
			@(posedge clk);
			if (!held_off && results_seen >= 60) begin
				held_off = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(posedge clk);
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 11);
				out_ready <= 1'b0;
				repeat (stall - 1) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_item(input stim_t s);
		int gap;
		gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 11) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cur_stim <= s;
		command <= s.cmd;
		step_count <= s.steps;
		job_length <= s.len;
		steps_per_mm <= s.spm;
		direction_in <= s.dir;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// Command with random payload in the fields it does not use.
	task automatic send_cmd(input logic [2:0] c);
		stim_t s;
		s = '0;
		s.cmd = c;
		s.steps = $urandom;
		s.len = 16'($urandom);
		s.spm = 16'($urandom);
		s.dir = 1'($urandom);
		send_item(s);
	endtask

	task automatic run_job_sequence();
		stim_t       s;
		logic [31:0] steps;
		int          slots;
		s = '0;
		if ($urandom_range(0, 9) == 0)
			send_cmd(3'($urandom_range(0, 7)));
		if ($urandom_range(0, 2) == 0) begin
			s.cmd = CMD_RUN_MM;
			s.dir = 1'($urandom);
			s.steps = $urandom;
			if ($urandom_range(0, 7) == 0) begin
				s.len = 16'($urandom);
				s.spm = 16'($urandom);
			end else begin
				s.len = 16'($urandom_range(0, 12));
				s.spm = 16'($urandom_range(0, 12));
			end
			steps = 32'(s.len) * 32'(s.spm);
		end else begin
			s.cmd = CMD_RUN_STEPS;
			s.steps = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 120);
			s.len = 16'($urandom);
			s.spm = 16'($urandom);
			s.dir = 1'($urandom);
			steps = s.steps;
		end
		send_item(s);
		slots = (steps / 5 > 30) ? 30 : int'(steps / 5) + $urandom_range(1, 3);
		repeat (slots) begin
			case ($urandom_range(0, 15))
				0: begin
					send_cmd(CMD_PAUSE);
					repeat ($urandom_range(1, 2)) send_cmd(CMD_SLOT);
					if ($urandom_range(0, 9) != 0)
						send_cmd(CMD_RESUME);
				end
				1: send_cmd(CMD_RESUME);
				2: send_cmd(3'($urandom_range(0, 7)));
				default: send_cmd(CMD_SLOT);
			endcase
		end
		if (job_busy && $urandom_range(0, 4) != 0)
			send_cmd(CMD_ABORT);
	endtask

	task automatic run_phase(input int n);
		int target;
		target = items_sent + n;
		while (items_sent < target)
			run_job_sequence();
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_RAMP_ENABLE: cfg_now.ramp_enable = val[0];
			REG_RAMP_LENGTH: cfg_now.ramp_length = val[15:0];
			REG_CRUISE_DIVIDER: cfg_now.cruise_divider = val[15:0];
			REG_SLOW_DIVIDER: cfg_now.slow_divider = val[15:0];
			REG_DIVIDER_STEP: cfg_now.divider_step = val[15:0];
			default: ;
		endcase
	endtask

	initial begin : stimulus
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIRECTED[i])
			send_item(DIRECTED[i]);
		run_phase(PHASE_ITEMS);
		foreach (RAMP_PROFILES[p]) begin
			drain();
			write_reg(REG_RAMP_ENABLE, 32'(RAMP_PROFILES[p].ramp_enable));
			write_reg(REG_RAMP_LENGTH, 32'(RAMP_PROFILES[p].ramp_length));
			write_reg(REG_CRUISE_DIVIDER, 32'(RAMP_PROFILES[p].cruise_divider));
			write_reg(REG_SLOW_DIVIDER, 32'(RAMP_PROFILES[p].slow_divider));
			write_reg(REG_DIVIDER_STEP, 32'(RAMP_PROFILES[p].divider_step));
			// The closing phase runs with no idling on either side.
			calm = (p == $size(RAMP_PROFILES) - 1);
			run_phase(PHASE_ITEMS);
		end
		drain();
		$display("Sent %0d commands (%0d acted on) and checked %0d results", items_sent,
			items_acted, results_seen);
		$display("over reset defaults and %0d ramp profiles; %0d failures.",
			$size(RAMP_PROFILES), failures);
		if (failures == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
